### hdl/ntad_pkg.sv
// shared types and constants for the number to ascii digit emitter
package ntad_pkg;

  // width of the value that is converted
  localparam int VALUE_BITS = 32;
  // bits of a bit counter that can hold VALUE_BITS itself
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  // decimal digits held by the bcd register
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = 4 * DEC_DIGITS;

  // depth of the queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // digit count limits by mode
  localparam logic [5:0] DEC_LIMIT = 6'd10;
  localparam logic [5:0] HEX_LIMIT = 6'd8;
  localparam logic [5:0] BIN_LIMIT = 6'd32;

  // ascii codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_BIN  = 2'd3
  } op_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    op_t                   op;
    logic                  is_dec;
    logic                  has_sign;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            count;
    logic [2:0]            line;
    logic [5:0]            col;
  } job_t;

endpackage

### hdl/ntad_front.sv
// front end: clamps the digit count and takes the magnitude in signed mode
module ntad_front (
  input  logic [1:0]        op,
  input  logic [31:0]       number,
  input  logic [5:0]        digit_count,
  input  logic [2:0]        text_line,
  input  logic [4:0]        start_column,
  output ntad_pkg::job_t    job
);

  ntad_pkg::op_t                   mode;
  logic [5:0]                      limit;
  logic [ntad_pkg::VALUE_BITS-1:0] val;
  logic                            neg;

  assign mode = ntad_pkg::op_t'(op);
  assign val  = number[ntad_pkg::VALUE_BITS-1:0];
  assign neg  = (mode == ntad_pkg::OP_SDEC) && val[ntad_pkg::VALUE_BITS-1];

  always_comb begin
    unique case (mode)
      ntad_pkg::OP_UDEC, ntad_pkg::OP_SDEC: limit = ntad_pkg::DEC_LIMIT;
      ntad_pkg::OP_HEX:                     limit = ntad_pkg::HEX_LIMIT;
      default:                              limit = ntad_pkg::BIN_LIMIT;
    endcase
  end

  always_comb begin
    job.op       = mode;
    job.is_dec   = (mode == ntad_pkg::OP_UDEC) || (mode == ntad_pkg::OP_SDEC);
    job.has_sign = (mode == ntad_pkg::OP_SDEC);
    job.neg      = neg;
    // most negative value wraps to itself, which reads right as unsigned
    job.mag      = neg ? (~val + 1'b1) : val;
    job.count    = (digit_count > limit) ? limit : digit_count;
    job.line     = text_line;
    job.col      = {1'b0, start_column};
  end

endmodule

### hdl/ntad_queue.sv
// short fifo of classified requests between front and back
module ntad_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ntad_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output ntad_pkg::job_t pop_data,
  output logic           not_empty
);

  ntad_pkg::job_t               entries [ntad_pkg::Q_DEPTH];
  logic [ntad_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [ntad_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [ntad_pkg::Q_CNT_W-1:0] cnt;
  logic                         do_push;
  logic                         do_pop;

  localparam logic [ntad_pkg::Q_PTR_W-1:0] PTR_LAST =
    ntad_pkg::Q_PTR_W'(ntad_pkg::Q_DEPTH - 1);
  localparam logic [ntad_pkg::Q_CNT_W-1:0] CNT_FULL =
    ntad_pkg::Q_CNT_W'(ntad_pkg::Q_DEPTH);

  assign full      = (cnt == CNT_FULL);
  assign not_empty = (cnt != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> full)
    else $error("queue lost an entry while full");

endmodule

### hdl/ntad_back.sv
// back end: shift-add-3 decimal conversion and per-character emission
module ntad_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ntad_pkg::job_t q_job,
  output logic           q_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     text_line_out,
  output logic [5:0]     column,
  output logic [6:0]     char_code,
  output logic           last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                          state;
  ntad_pkg::job_t                  job;
  logic [ntad_pkg::VALUE_BITS-1:0] shreg;
  logic [ntad_pkg::BCD_W-1:0]      bcd;
  logic [ntad_pkg::BCD_W-1:0]      bcd_adj;
  logic [ntad_pkg::CNT_W-1:0]      bit_cnt;
  logic [5:0]                      remain;
  logic [5:0]                      col;
  logic                            sign_pend;
  logic                            load;
  logic                            is_last;
  logic                            skip;
  logic [4:0]                      pos;
  logic [3:0]                      digit;
  logic [6:0]                      ch;

  assign q_ready = (state == ST_IDLE);
  assign load    = (state == ST_EMIT) && (!out_valid || out_ready);
  assign is_last = sign_pend ? (remain == 6'd0) : (remain == 6'd1);
  assign pos     = 5'(remain - 6'd1);
  // nothing at all to emit for an unsigned run of zero digits
  assign skip    = !q_job.has_sign && (q_job.count == 6'd0);

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < ntad_pkg::DEC_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3
                                                  : bcd[4*d +: 4];
    end
  end

  always_comb begin
    unique case (job.op)
      ntad_pkg::OP_UDEC, ntad_pkg::OP_SDEC: digit = bcd[{pos[3:0], 2'b00} +: 4];
      ntad_pkg::OP_HEX:                     digit = job.mag[{pos[2:0], 2'b00} +: 4];
      default:                              digit = {3'b000, job.mag[pos]};
    endcase
    if (sign_pend) begin
      ch = job.neg ? ntad_pkg::CH_MINUS : ntad_pkg::CH_PLUS;
    end else if (digit < 4'd10) begin
      ch = ntad_pkg::CH_ZERO + {3'b000, digit};
    end else begin
      ch = ntad_pkg::CH_A + {3'b000, digit} - 7'd10;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !skip) begin
            state <= q_job.is_dec ? ST_CONV : ST_EMIT;
          end
        end
        ST_CONV: begin
          if (bit_cnt == ntad_pkg::CNT_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load && is_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          job       <= q_job;
          shreg     <= q_job.mag;
          bcd       <= '0;
          bit_cnt   <= ntad_pkg::CNT_W'(ntad_pkg::VALUE_BITS);
          remain    <= q_job.count;
          col       <= q_job.col;
          sign_pend <= q_job.has_sign;
        end
      end
      ST_CONV: begin
        bcd     <= {bcd_adj[ntad_pkg::BCD_W-2:0], shreg[ntad_pkg::VALUE_BITS-1]};
        shreg   <= {shreg[ntad_pkg::VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
      end
      ST_EMIT: begin
        if (load) begin
          text_line_out <= job.line;
          column        <= col;
          char_code     <= ch;
          last          <= is_last;
          col           <= col + 6'd1;
          if (sign_pend) begin
            sign_pend <= 1'b0;
          end else begin
            remain <= remain - 6'd1;
          end
        end
      end
      default: ;
    endcase
  end

  a_conv_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV |-> bit_cnt != '0)
    else $error("conversion running with no bits left");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load && is_last |=> state == ST_IDLE && out_valid && last)
    else $error("final character did not end the run");

  a_dec_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && job.is_dec |-> remain <= ntad_pkg::DEC_LIMIT)
    else $error("decimal digit position beyond bcd register");

  a_emit_some: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> sign_pend || remain != 6'd0)
    else $error("emit state with nothing left to send");

endmodule

### hdl/number_to_ascii_digits.sv
// top level of the number to ascii digit emitter
// path: a request goes through the queue, the back idle state and the emit state to the output register;
//   decimal modes also run the 32-step shift-add-3 bcd conversion between idle and emit
// the back takes a new request only once it is idle again after the last character of the one before;
//   at most one character per cycle from the output register, held while out_ready is low
// reset: rst synchronous active high, clears the queue, the back state and out_valid
module number_to_ascii_digits (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] number,
  input  logic [5:0]  digit_count,
  input  logic [2:0]  text_line,
  input  logic [4:0]  start_column,
  // character channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  text_line_out,
  output logic [5:0]  column,
  output logic [6:0]  char_code,
  output logic        last
);

  ntad_pkg::job_t front_job;
  ntad_pkg::job_t q_job;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;

  // front: clamp the digit count, pull the sign off signed values
  ntad_front u_front (
    .op           (op),
    .number       (number),
    .digit_count  (digit_count),
    .text_line    (text_line),
    .start_column (start_column),
    .job          (front_job)
  );

  // a request transfers in whenever the queue has room, even mid-run in the back
  assign in_ready = !q_full;

  ntad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_job),
    .not_empty (q_not_empty)
  );

  // back: converts one request at a time and streams its characters
  ntad_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_not_empty),
    .q_job         (q_job),
    .q_ready       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .text_line_out (text_line_out),
    .column        (column),
    .char_code     (char_code),
    .last          (last)
  );

endmodule

### dv/ntad_char_scoreboard.sv
`timescale 1ns / 100ps
// character scoreboard for the number to ascii digit emitter testbench
package ntad_char_check_pkg;
  import ntad_pkg::*;

  typedef struct packed {
    logic [2:0] line;
    logic [5:0] col;
    logic [6:0] code;
    logic       lst;
  } char_rec_t;

  class char_scoreboard;
    char_rec_t   pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // expand one accepted request into the characters it must produce
    function void note_request(op_t op, logic [31:0] number, logic [5:0] digit_count,
                               logic [2:0] line, logic [4:0] start_col);
      logic [VALUE_BITS-1:0] mag;
      logic [5:0]            lim;
      logic [5:0]            cnt;
      logic [5:0]            col;
      longint unsigned       m;
      int unsigned           d;
      int unsigned           pos;
      char_rec_t             rec;
      mag = number[VALUE_BITS-1:0];
      col = {1'b0, start_col};
      case (op)
        OP_HEX:  lim = HEX_LIMIT;
        OP_BIN:  lim = BIN_LIMIT;
        default: lim = DEC_LIMIT;
      endcase
      cnt = (digit_count > lim) ? lim : digit_count;
      rec.line = line;
      if (op == OP_SDEC) begin
        rec.col  = col;
        rec.code = mag[VALUE_BITS-1] ? CH_MINUS : CH_PLUS;
        rec.lst  = (cnt == 6'd0);
        if (mag[VALUE_BITS-1]) mag = ~mag + 1'b1;
        pending.push_back(rec);
        col = col + 6'd1;
      end
      for (int i = 0; i < int'(cnt); i++) begin
        pos = int'(cnt) - i - 1;
        case (op)
          OP_HEX: d = int'((mag >> (4 * pos)) & 'hF);
          OP_BIN: d = int'(mag[pos]);
          default: begin
            m = longint'(mag);
            repeat (pos) m = m / 10;
            d = int'(m % 10);
          end
        endcase
        rec.col  = col + 6'(i);
        rec.code = (d < 10) ? CH_ZERO + 7'(d) : CH_A + 7'(d - 10);
        rec.lst  = (i + 1 == int'(cnt));
        pending.push_back(rec);
      end
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one transferred character with the oldest expected one
    task check_char(input logic [2:0] line, input logic [5:0] col,
                    input logic [6:0] code, input logic lst);
      char_rec_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h at line %0d col %0d", code, line, col));
        return;
      end
      want = pending.pop_front();
      if (line !== want.line)
        report_mismatch($sformatf("text line %0d, want %0d", line, want.line));
      if (col !== want.col)
        report_mismatch($sformatf("column %0d, want %0d", col, want.col));
      if (code !== want.code)
        report_mismatch($sformatf("char %02h, want %02h at col %0d", code, want.code, want.col));
      if (lst !== want.lst)
        report_mismatch($sformatf("last %b, want %b at col %0d", lst, want.lst, want.col));
    endtask
  endclass

endpackage

### dv/number_to_ascii_digits_tb.sv
`timescale 1ns / 100ps
// testbench top for the number to ascii digit emitter
module number_to_ascii_digits_tb;
  import ntad_pkg::*;
  import ntad_char_check_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 80;   // covers the decimal conversion
  localparam int PHASE_ITEMS = 112;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [31:0] number;
  logic [5:0]  digit_count;
  logic [2:0]  text_line;
  logic [4:0]  start_column;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  text_line_out;
  logic [5:0]  column;
  logic [6:0]  char_code;
  logic        last;

  int unsigned    idle_pct;
  int unsigned    stall_pct;
  int unsigned    cycles;
  char_scoreboard sb;

  number_to_ascii_digits dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .number        (number),
    .digit_count   (digit_count),
    .text_line     (text_line),
    .start_column  (start_column),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .text_line_out (text_line_out),
    .column        (column),
    .char_code     (char_code),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
  end
  always #4 clk = ~clk;

  // receiver side: back-pressure decided fresh every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // both channels are sampled at the rising edge, where transfers happen
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_request(op_t'(op), number, digit_count, text_line, start_column);
    if (!rst && out_valid && out_ready)
      sb.check_char(text_line_out, column, char_code, last);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still expected", cycles, sb.outstanding());
      $display("FAIL number_to_ascii_digits");
      $finish;
    end
  end

  // present one request and hold it until the transfer; called at a falling edge
  task automatic send_request(input op_t o, input logic [31:0] n, input logic [5:0] dc,
                              input logic [2:0] tl, input logic [4:0] sc);
    in_valid     <= 1'b1;
    op           <= o;
    number       <= n;
    digit_count  <= dc;
    text_line    <= tl;
    start_column <= sc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // sender gap: in_valid drops while random draws fall under idle_pct
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // hold the sender off until every expected character has come back
  task automatic drain_chars();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic send_random_request();
    op_t         o;
    logic [31:0] n;
    logic [5:0]  lim;
    logic [5:0]  dc;
    o = op_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       n = $urandom_range(0, 999);
      1:       n = 32'h8000_0000 + $urandom_range(0, 3) - 2;
      2:       n = 32'hFFFF_FFFF - $urandom_range(0, 15);
      3:       n = 32'd1 << $urandom_range(0, 31);
      4:       n = 32'd0 - $urandom_range(0, 999);
      default: n = $urandom;
    endcase
    case (o)
      OP_HEX:  lim = HEX_LIMIT;
      OP_BIN:  lim = BIN_LIMIT;
      default: lim = DEC_LIMIT;
    endcase
    // mostly counts around the mode limit, some zero, some anywhere in the field
    case ($urandom_range(0, 19))
      0:          dc = 6'd0;
      1, 2, 3:    dc = 6'($urandom_range(0, 63));
      default:    dc = 6'($urandom_range(1, lim + 1));
    endcase
    send_request(o, n, dc, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    op           = OP_UDEC;
    number       = '0;
    digit_count  = '0;
    text_line    = '0;
    start_column = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every mode, clamping, empty runs, sign corners
    send_request(OP_UDEC, 32'd0,          6'd10, 3'd1, 5'd1);
    send_request(OP_UDEC, 32'hFFFF_FFFF,  6'd10, 3'd7, 5'd31);
    send_request(OP_UDEC, 32'd1234567890, 6'd63, 3'd0, 5'd0);
    send_request(OP_UDEC, 32'd987654321,  6'd3,  3'd4, 5'd16);
    send_request(OP_UDEC, 32'd55,         6'd0,  3'd2, 5'd5);
    send_request(OP_SDEC, 32'h8000_0000,  6'd10, 3'd1, 5'd1);
    send_request(OP_SDEC, 32'h7FFF_FFFF,  6'd10, 3'd2, 5'd0);
    send_request(OP_SDEC, 32'hFFFF_FFFF,  6'd1,  3'd3, 5'd31);
    send_request(OP_SDEC, 32'hFFFF_FF85,  6'd0,  3'd4, 5'd8);
    send_request(OP_SDEC, 32'd0,          6'd0,  3'd5, 5'd2);
    send_request(OP_SDEC, 32'd42,         6'd40, 3'd6, 5'd3);
    send_request(OP_HEX,  32'hFFFF_FFFF,  6'd8,  3'd7, 5'd31);
    send_request(OP_HEX,  32'h0123_ABCD,  6'd8,  3'd1, 5'd1);
    send_request(OP_HEX,  32'hFEDC_BA98,  6'd9,  3'd0, 5'd0);
    send_request(OP_HEX,  32'h0000_00EF,  6'd0,  3'd2, 5'd4);
    send_request(OP_HEX,  32'h7654_3210,  6'd3,  3'd3, 5'd12);
    send_request(OP_BIN,  32'hAAAA_AAAA,  6'd32, 3'd4, 5'd31);
    send_request(OP_BIN,  32'h5555_5555,  6'd63, 3'd5, 5'd0);
    send_request(OP_BIN,  32'hFFFF_FFFF,  6'd0,  3'd6, 5'd7);
    send_request(OP_BIN,  32'h0000_0000,  6'd32, 3'd7, 5'd1);
    send_request(OP_BIN,  32'h8000_0001,  6'd1,  3'd0, 5'd20);
    drain_chars();

    // random traffic under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random_request();
        if (phase == 0 && k == PHASE_ITEMS / 2) drain_chars();
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS number_to_ascii_digits");
    end else begin
      $display("FAIL number_to_ascii_digits");
    end
    $finish;
  end

endmodule
